@@ sv/ordered_tag_match_queue_defines.svh @@
// Assertion macros used by the ordered tag match queue entry store.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef ORDERED_TAG_MATCH_QUEUE_DEFINES_SVH
`define ORDERED_TAG_MATCH_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define OTMQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define OTMQ_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define OTMQ_ASSERT(lbl, prop, msg)
`define OTMQ_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ sv/otmq_pkg.sv @@
// Types, codes and widths shared by the ordered tag match queue modules.
// Depends on nothing.
package otmq_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int FIFO_DEPTH    = 2;

   localparam int OP_W     = 2;
   localparam int TAG_W    = 64;
   localparam int SRC_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;

   localparam int REQ_TAG_LO    = 0;
   localparam int REQ_MASK_LO   = REQ_TAG_LO + TAG_W;
   localparam int REQ_SRC_LO    = REQ_MASK_LO + TAG_W;
   localparam int REQ_HANDLE_LO = REQ_SRC_LO + SRC_W;
   localparam int REQ_DATA_W    = REQ_HANDLE_LO + HANDLE_W;

   localparam logic [SRC_W-1:0] SRC_ANY = '1;

   localparam logic [OP_W-1:0] OP_POST      = 2'd0;
   localparam logic [OP_W-1:0] OP_MATCH_TAG = 2'd1;
   localparam logic [OP_W-1:0] OP_MATCH_SRC = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_POSTED  = 2'd0,
      ST_FULL    = 2'd1,
      ST_MATCHED = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      K_POST,
      K_MATCH_TAG,
      K_MATCH_SRC,
      K_NONE
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [TAG_W-1:0]      tag;
      logic [TAG_W-1:0]      mask;
      logic [SRC_W-1:0]      src;
      logic [HANDLE_W-1:0]   handle;
   } item_type;

   typedef struct packed {
      logic cmp_en;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic                  full;
      logic                  hit;
      logic [HANDLE_W-1:0]   handle;
   } result_type;

endpackage

@@ sv/ordered_tag_match_queue.sv @@
// Ordered tag match queue: top level; depends on otmq_pkg, otmq_front, otmq_back, otmq_entries.
// A request passes the front queue, the back end's command register, the registered hit vector
// and the response register. Items go one at a time: a registered parallel compare followed by
// the commit cycle that updates the entry array; a stalled response holds back the commit.
// Reset clears the entry count, the request queue and the response valid; entries are not cleared.
module ordered_tag_match_queue #(
   parameter int QUEUE_DEPTH = otmq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata fields from bit 0: tag, ignore_mask, source_id, handle.
   input  logic [otmq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser fields from bit 0: operation.
   input  logic [otmq_pkg::OP_W-1:0]         req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata fields from bit 0: matched_handle.
   output logic [otmq_pkg::HANDLE_W-1:0]     rsp_tdata,
   // tuser fields from bit 0: status.
   output logic [otmq_pkg::STATUS_W-1:0]     rsp_tuser
);

   // The front end decodes each request into a kind and parks it in a
   // two-entry queue, so the request side keeps moving while the back end
   // is busy or the response register is stalled.
   logic                 item_valid;
   logic                 item_pop;
   otmq_pkg::item_type   item;

   // The back end holds the item under execution and tells the entry
   // store when to compare and when to commit.
   otmq_pkg::item_type   cmd;
   otmq_pkg::ctrl_type   ctrl;
   otmq_pkg::result_type result;

   otmq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // The entry store compares every live entry in parallel during the
   // compare cycle and registers the hit vector. In the commit cycle the
   // oldest hit is picked, its handle returned, and every entry above it
   // moves down one place so that age order is kept.
   otmq_entries #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .ctrl   (ctrl),
      .result (result)
   );

   // The response register decouples the result side: a finished result
   // waits there while the next item is already being compared.
   otmq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .cmd        (cmd),
      .ctrl       (ctrl),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/otmq_front.sv @@
// Front end: decodes the operation of each request and buffers it in a short queue.
// Depends on otmq_pkg.
module otmq_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [otmq_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [otmq_pkg::OP_W-1:0]            req_tuser,
   output logic                                 item_valid,
   output otmq_pkg::item_type                   item,
   input  logic                                 item_pop
);

   localparam int PTR_W = (otmq_pkg::FIFO_DEPTH > 1) ? $clog2(otmq_pkg::FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(otmq_pkg::FIFO_DEPTH + 1);

   otmq_pkg::item_type item_ff [otmq_pkg::FIFO_DEPTH];
   otmq_pkg::item_type item_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push;

   always_comb begin
      item_in.tag    = req_tdata[otmq_pkg::REQ_TAG_LO    +: otmq_pkg::TAG_W];
      item_in.mask   = req_tdata[otmq_pkg::REQ_MASK_LO   +: otmq_pkg::TAG_W];
      item_in.src    = req_tdata[otmq_pkg::REQ_SRC_LO    +: otmq_pkg::SRC_W];
      item_in.handle = req_tdata[otmq_pkg::REQ_HANDLE_LO +: otmq_pkg::HANDLE_W];
      case (req_tuser)
         otmq_pkg::OP_POST:      item_in.kind = otmq_pkg::K_POST;
         otmq_pkg::OP_MATCH_TAG: item_in.kind = otmq_pkg::K_MATCH_TAG;
         otmq_pkg::OP_MATCH_SRC: item_in.kind = otmq_pkg::K_MATCH_SRC;
         default:                item_in.kind = otmq_pkg::K_NONE;
      endcase
   end

   assign req_tready = (cnt_ff != CNT_W'(otmq_pkg::FIFO_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != '0);
   assign item       = item_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(otmq_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(otmq_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ sv/otmq_entries.sv @@
// Entry store: posted receives in age order, parallel compare and ordered compaction.
// Depends on otmq_pkg and ordered_tag_match_queue_defines.svh.
`include "ordered_tag_match_queue_defines.svh"
module otmq_entries #(
   parameter int QUEUE_DEPTH = otmq_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  otmq_pkg::item_type   cmd,
   input  otmq_pkg::ctrl_type   ctrl,
   output otmq_pkg::result_type result
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [otmq_pkg::TAG_W-1:0]    tag_ff  [QUEUE_DEPTH];
   logic [otmq_pkg::TAG_W-1:0]    mask_ff [QUEUE_DEPTH];
   logic [otmq_pkg::SRC_W-1:0]    src_ff  [QUEUE_DEPTH];
   logic [otmq_pkg::HANDLE_W-1:0] hnd_ff  [QUEUE_DEPTH];

   logic [CNT_W-1:0]              count_ff, count_in;
   logic [QUEUE_DEPTH-1:0]        hit_ff, hit_in;
   logic [QUEUE_DEPTH-1:0]        neg_hit, first_hit, shift_en;
   logic [otmq_pkg::HANDLE_W-1:0] sel_handle;
   logic [IDX_W-1:0]              wr_idx;
   logic                          full, hit_any, is_match;

   assign is_match = (cmd.kind == otmq_pkg::K_MATCH_TAG) || (cmd.kind == otmq_pkg::K_MATCH_SRC);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign hit_any  = |hit_ff;
   assign wr_idx   = count_ff[IDX_W-1:0];

   // Each live entry compares against the incoming tag on its own.
   always_comb begin
      logic tag_ok, src_ok;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         tag_ok = ((tag_ff[i] | mask_ff[i]) == (cmd.tag | mask_ff[i]));
         src_ok = (cmd.kind != otmq_pkg::K_MATCH_SRC) || (src_ff[i] == otmq_pkg::SRC_ANY)
                  || (cmd.src == otmq_pkg::SRC_ANY) || (src_ff[i] == cmd.src);
         hit_in[i] = is_match && (CNT_W'(i) < count_ff) && tag_ok && src_ok;
      end
   end

   // Two's complement of the hit vector, ANDed with it, isolates the oldest hit, and ORed
   // with the hits marks every entry at or above it, which all move down one.
   assign neg_hit   = ~hit_ff + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1};
   assign first_hit = hit_ff & neg_hit;
   assign shift_en  = hit_ff | neg_hit;

   always_comb begin
      sel_handle = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_handle = sel_handle | (hnd_ff[i] & {otmq_pkg::HANDLE_W{first_hit[i]}});
      end
   end

   assign result.full   = full;
   assign result.hit    = hit_any;
   assign result.handle = sel_handle;

   always_comb begin
      count_in = count_ff;
      if (ctrl.commit) begin
         if (cmd.kind == otmq_pkg::K_POST && !full) begin
            count_in = count_ff + 1'b1;
         end else if (is_match && hit_any) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hit_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (ctrl.cmp_en) begin
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         if (cmd.kind == otmq_pkg::K_POST && !full) begin
            tag_ff[wr_idx]  <= cmd.tag;
            mask_ff[wr_idx] <= cmd.mask;
            src_ff[wr_idx]  <= cmd.src;
            hnd_ff[wr_idx]  <= cmd.handle;
         end else if (is_match && hit_any) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               if (shift_en[i]) begin
                  tag_ff[i]  <= tag_ff[i+1];
                  mask_ff[i] <= mask_ff[i+1];
                  src_ff[i]  <= src_ff[i+1];
                  hnd_ff[i]  <= hnd_ff[i+1];
               end
            end
         end
      end
   end

   `OTMQ_ASSERT_NEVER(a_count_bound, count_ff > CNT_W'(QUEUE_DEPTH), "entry count above depth")
   `OTMQ_ASSERT_NEVER(a_cmp_commit_excl, ctrl.cmp_en && ctrl.commit, "compare and commit together")
   `OTMQ_ASSERT(a_post_grows, ctrl.commit && cmd.kind == otmq_pkg::K_POST && !full |=> count_ff == $past(count_ff) + 1'b1, "post did not grow queue")
   `OTMQ_ASSERT(a_match_shrinks, ctrl.commit && is_match && hit_any |=> count_ff == $past(count_ff) - 1'b1, "match did not shrink queue")

endmodule

@@ sv/otmq_back.sv @@
// Back end: sequences compare and commit for one item at a time and holds the response.
// Depends on otmq_pkg.
module otmq_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  otmq_pkg::item_type                item,
   output logic                              item_pop,
   output otmq_pkg::item_type                cmd,
   output otmq_pkg::ctrl_type                ctrl,
   input  otmq_pkg::result_type              result,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [otmq_pkg::HANDLE_W-1:0]     rsp_tdata,
   output logic [otmq_pkg::STATUS_W-1:0]     rsp_tuser
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   otmq_pkg::item_type            cmd_ff, cmd_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   otmq_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [otmq_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   otmq_pkg::status_type          status;
   logic [otmq_pkg::HANDLE_W-1:0] out_handle;
   logic                          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (cmd_ff.kind)
         otmq_pkg::K_POST: begin
            status     = result.full ? otmq_pkg::ST_FULL : otmq_pkg::ST_POSTED;
            out_handle = '0;
         end
         otmq_pkg::K_MATCH_TAG, otmq_pkg::K_MATCH_SRC: begin
            status     = result.hit ? otmq_pkg::ST_MATCHED : otmq_pkg::ST_NOMATCH;
            out_handle = result.hit ? result.handle : '0;
         end
         default: begin
            status     = otmq_pkg::ST_NOMATCH;
            out_handle = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      item_pop      = 1'b0;
      ctrl          = '0;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cmd_in   = item;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctrl.cmp_en = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               ctrl.commit   = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status;
               rsp_handle_in = out_handle;
               if (item_valid) begin
                  item_pop = 1'b1;
                  cmd_in   = item;
                  state_in = S_CMP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign cmd        = cmd_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_handle_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
